### hw/rtl/dls_pkg.sv
package dls_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned REG_W  = 3;

  typedef enum logic [1:0] {
    OP_STEP = 2'd0,
    OP_READ = 2'd1,
    OP_INIT = 2'd2,
    OP_NONE = 2'd3
  } dls_op_e;

  typedef enum logic [REG_W-1:0] {
    REG_RATE_HIGH  = 3'd0,
    REG_RATE_LOW   = 3'd1,
    REG_LEVEL_HIGH = 3'd2,
    REG_LEVEL_LOW  = 3'd3,
    REG_SWITCH     = 3'd4,
    REG_CLAMP      = 3'd5,
    REG_INIT_FILL  = 3'd6,
    REG_SPARE      = 3'd7
  } dls_reg_e;

  // one cell update request: neighbourhood of the cell being advanced
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] centre;
    logic [VAL_W-1:0] right;
  } dls_calc_t;

endpackage

### hw/rtl/dls_ram.sv
module dls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dls_alu.sv
module dls_alu (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dls_pkg::dls_calc_t             req_i,
  input  logic [dls_pkg::RATE_W-1:0]     rate_i,
  output logic                           vld_o,
  output logic [dls_pkg::VAL_W-1:0]      next_o
);

  localparam int unsigned LAP_W  = dls_pkg::VAL_W + 2;
  localparam int unsigned PROD_W = LAP_W + dls_pkg::RATE_W + 1;

  logic signed [LAP_W-1:0]  lap;
  logic signed [PROD_W-1:0] prod;
  logic                     vld_q;
  logic [dls_pkg::VAL_W-1:0] term_q;
  logic [dls_pkg::VAL_W-1:0] centre_q;

  // right + left - 2c, exact
  assign lap = $signed({{2{req_i.left[dls_pkg::VAL_W-1]}}, req_i.left})
             + $signed({{2{req_i.right[dls_pkg::VAL_W-1]}}, req_i.right})
             - $signed({req_i.centre[dls_pkg::VAL_W-1], req_i.centre, 1'b0});

  assign prod = PROD_W'(lap) * PROD_W'($signed({1'b0, rate_i}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.vld;
    end
  end

  // floor by 16 then wrap to 32 bits
  always_ff @(posedge clk_i) begin
    if (req_i.vld) begin
      term_q   <= prod[dls_pkg::VAL_W+15:16];
      centre_q <= req_i.centre;
    end
  end

  assign vld_o  = vld_q;
  assign next_o = centre_q + term_q;

endmodule

### hw/rtl/diffusion_line_step_core.sv
// channel  dir  tdata bits                                            tlast tuser
// s_axis   in   [1:0] operation, [8:2] cell_index, [15:9] zero        -     -
// m_axis   out  [31:0] cell_value, [38:32] cell_number,               -     -
//               [39] environment_high, [55:40] period_position
// cfg      in   cfg_we_i / cfg_index_i / cfg_data_i, write only
//
// Step: one cell per cycle through the shared multiply unit.
// Read: registered RAM read. Initialize: fills every cell. Unused op: no RAM access.
// After reset the cell RAM is cleared to zero; no beat is taken meanwhile.
// One item at a time; a finished result waits in the output register, and the
// block accepts the next beat while it waits, stalling only when a second result is due.
module diffusion_line_step_core #(
  parameter int unsigned CELLS = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // operation, cell_index
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [55:0]                   m_axis_tdata,   // cell_value, cell_number,
                                                        // environment_high, period_position
  input  logic                          cfg_we_i,
  input  logic [dls_pkg::REG_W-1:0]     cfg_index_i,
  input  logic [dls_pkg::VAL_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CW = $clog2(CELLS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [CW-1:0] LAST_CNT  = CW'(CELLS - 1);
  localparam logic [CW-1:0] END_CNT   = CW'(CELLS);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_STEP  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_INIT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [dls_pkg::RATE_W-1:0] rate_high_q, rate_low_q;
  logic [dls_pkg::VAL_W-1:0]  level_high_q, level_low_q, init_fill_q;
  logic [dls_pkg::CNT_W-1:0]  switch_q;
  logic [7:0]                 clamp_q;

  logic [dls_pkg::CNT_W-1:0]  period_q, period_d;
  logic                       high_q, high_d;

  logic [CW-1:0]              rd_cnt_q, rd_cnt_d;
  logic                       rd_vld_q, rd_vld_d;
  logic [AW-1:0]              rd_idx_q, rd_idx_d;
  logic                       last_q, last_d;
  logic [dls_pkg::VAL_W-1:0]  left_q, left_d, mid_q, mid_d;
  logic [CW-1:0]              wr_cnt_q, wr_cnt_d;
  logic [AW-1:0]              waddr_q, waddr_d;
  logic                       rd_ok_q, rd_ok_d;

  logic [dls_pkg::VAL_W-1:0]  res_value_q, res_value_d;
  logic [dls_pkg::IDX_W-1:0]  res_num_q, res_num_d;

  logic                       out_vld_q;
  logic [dls_pkg::VAL_W-1:0]  out_value_q;
  logic [dls_pkg::IDX_W-1:0]  out_num_q;
  logic                       out_high_q;
  logic [dls_pkg::CNT_W-1:0]  out_period_q;
  logic                       out_load;

  logic                       in_beat;
  logic [1:0]                 in_op;
  logic [dls_pkg::IDX_W-1:0]  in_idx;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [dls_pkg::VAL_W-1:0]  ram_wdata, ram_rdata;

  dls_pkg::dls_calc_t         calc;
  logic [AW-1:0]              calc_addr;
  logic                       alu_vld;
  logic [dls_pkg::VAL_W-1:0]  alu_next;

  logic [dls_pkg::VAL_W-1:0]  cur_val;
  logic [dls_pkg::VAL_W-1:0]  level_sel;
  logic [dls_pkg::VAL_W-1:0]  fill_val;
  logic [dls_pkg::CNT_W-1:0]  period_inc;
  logic                       rd_issue;
  logic                       step_end;

  assign in_op   = s_axis_tdata[1:0];
  assign in_idx  = s_axis_tdata[8:2];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat = s_axis_tvalid && s_axis_tready;

  assign level_sel = high_q ? level_high_q : level_low_q;
  assign fill_val  = (32'(wr_cnt_q) < 32'(clamp_q)) ? level_high_q : init_fill_q;
  assign cur_val   = (32'(rd_idx_q) < 32'(clamp_q)) ? level_sel : ram_rdata;
  assign rd_issue  = (state_q == ST_STEP) && (rd_cnt_q < END_CNT);
  assign step_end  = (state_q == ST_STEP) && alu_vld && (waddr_q == LAST_ADDR);
  assign period_inc = period_q + 16'd1;
  assign out_load  = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_high_q  <= 16'd3041;
      rate_low_q   <= 16'd1094;
      level_high_q <= 32'd6553600;
      level_low_q  <= 32'd655360;
      switch_q     <= 16'd3333;
      clamp_q      <= 8'd11;
      init_fill_q  <= 32'd655360;
    end else if (cfg_we_i) begin
      case (dls_pkg::dls_reg_e'(cfg_index_i))
        dls_pkg::REG_RATE_HIGH:  rate_high_q  <= cfg_data_i[dls_pkg::RATE_W-1:0];
        dls_pkg::REG_RATE_LOW:   rate_low_q   <= cfg_data_i[dls_pkg::RATE_W-1:0];
        dls_pkg::REG_LEVEL_HIGH: level_high_q <= cfg_data_i;
        dls_pkg::REG_LEVEL_LOW:  level_low_q  <= cfg_data_i;
        dls_pkg::REG_SWITCH:     switch_q     <= cfg_data_i[dls_pkg::CNT_W-1:0];
        dls_pkg::REG_CLAMP:      clamp_q      <= cfg_data_i[7:0];
        dls_pkg::REG_INIT_FILL:  init_fill_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    period_d    = period_q;
    high_d      = high_q;
    rd_cnt_d    = rd_cnt_q;
    rd_vld_d    = rd_issue;
    rd_idx_d    = rd_cnt_q[AW-1:0];
    last_d      = last_q;
    left_d      = left_q;
    mid_d       = mid_q;
    wr_cnt_d    = wr_cnt_q;
    waddr_d     = waddr_q;
    rd_ok_d     = rd_ok_q;
    res_value_d = res_value_q;
    res_num_d   = res_num_q;
    calc        = '0;
    calc_addr   = '0;

    case (state_q)
      ST_CLEAR: begin
        wr_cnt_d = wr_cnt_q + 1'b1;
        if (wr_cnt_q == LAST_CNT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          rd_cnt_d    = '0;
          wr_cnt_d    = '0;
          last_d      = 1'b0;
          res_value_d = '0;
          res_num_d   = '0;
          rd_ok_d     = 32'(in_idx) < 32'(CELLS);
          case (dls_pkg::dls_op_e'(in_op))
            dls_pkg::OP_STEP: state_d = ST_STEP;
            dls_pkg::OP_READ: begin
              state_d   = ST_READ;
              res_num_d = in_idx;
            end
            dls_pkg::OP_INIT: state_d = ST_INIT;
            default:          state_d = ST_DONE;
          endcase
        end
      end
      ST_STEP: begin
        if (rd_issue) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        // cell m is advanced once cell m+1 has arrived
        if (rd_vld_q) begin
          mid_d  = cur_val;
          left_d = mid_q;
          last_d = (rd_idx_q == LAST_ADDR);
          if (rd_idx_q != '0) begin
            calc.vld    = 1'b1;
            calc.centre = mid_q;
            calc.left   = (rd_idx_q == AW'(1)) ? mid_q : left_q;
            calc.right  = cur_val;
            calc_addr   = rd_idx_q - 1'b1;
          end
        end else if (last_q) begin
          last_d      = 1'b0;
          calc.vld    = 1'b1;
          calc.centre = mid_q;
          calc.left   = left_q;
          calc.right  = mid_q;
          calc_addr   = LAST_ADDR;
        end
        if (calc.vld) begin
          waddr_d = calc_addr;
        end
        if (step_end) begin
          state_d = ST_DONE;
          if (period_inc >= switch_q) begin
            period_d = '0;
            high_d   = !high_q;
          end else begin
            period_d = period_inc;
          end
        end
      end
      ST_READ: begin
        res_value_d = rd_ok_q ? ram_rdata : '0;
        state_d     = ST_DONE;
      end
      ST_INIT: begin
        wr_cnt_d = wr_cnt_q + 1'b1;
        if (wr_cnt_q == LAST_CNT) begin
          period_d = '0;
          high_d   = 1'b1;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      period_q <= '0;
      high_q   <= 1'b1;
      rd_cnt_q <= '0;
      rd_vld_q <= 1'b0;
      last_q   <= 1'b0;
      wr_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      period_q <= period_d;
      high_q   <= high_d;
      rd_cnt_q <= rd_cnt_d;
      rd_vld_q <= rd_vld_d;
      last_q   <= last_d;
      wr_cnt_q <= wr_cnt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    left_q      <= left_d;
    mid_q       <= mid_d;
    waddr_q     <= waddr_d;
    rd_ok_q     <= rd_ok_d;
    res_value_q <= res_value_d;
    res_num_q   <= res_num_d;
    if (out_load) begin
      out_value_q  <= res_value_q;
      out_num_q    <= res_num_q;
      out_high_q   <= high_q;
      out_period_q <= period_q;
    end
  end

  assign ram_re    = rd_issue || (in_beat && (dls_pkg::dls_op_e'(in_op) == dls_pkg::OP_READ));
  assign ram_raddr = (state_q == ST_STEP) ? rd_cnt_q[AW-1:0] : AW'(in_idx);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_cnt_q[AW-1:0];
    ram_wdata = '0;
    case (state_q)
      ST_CLEAR: ram_we = 1'b1;
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = fill_val;
      end
      ST_STEP: begin
        ram_we    = alu_vld;
        ram_waddr = waddr_q;
        ram_wdata = alu_next;
      end
      default: ;
    endcase
  end

  dls_ram #(
    .WIDTH (dls_pkg::VAL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dls_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (calc),
    .rate_i (high_q ? rate_high_q : rate_low_q),
    .vld_o  (alu_vld),
    .next_o (alu_next)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_period_q, out_high_q, out_num_q, out_value_q};

  // write-back trails the read sweep, so old values are never overwritten early
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("cell write hits the address being read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_end |-> (rd_cnt_q == END_CNT) && !rd_vld_q && !last_q)
    else $error("step finished with reads outstanding");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !alu_vld && !rd_vld_q)
    else $error("update unit busy while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_vld_q && !m_axis_tready) |=> (state_q == ST_DONE))
    else $error("result dropped while output stalled");

endmodule
